/* rtl/rau_pkg.sv */
// ---------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
  localparam int W = 32;
  localparam int CW = 6;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // multiplier operand selects
  localparam logic [1:0] M_AN_BD = 2'd0;
  localparam logic [1:0] M_AD_BN = 2'd1;
  localparam logic [1:0] M_AD_BD = 2'd2;
  localparam logic [1:0] M_AN_BN = 2'd3;

  // destination of a product
  localparam logic [1:0] P_NUM  = 2'd0;
  localparam logic [1:0] P_DEN  = 2'd1;
  localparam logic [1:0] P_TMP  = 2'd2;
  localparam logic [1:0] P_SUM  = 2'd3;

  // divider jobs
  localparam logic [1:0] D_REM  = 2'd0;
  localparam logic [1:0] D_QNUM = 2'd1;
  localparam logic [1:0] D_QDEN = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic [1:0] msel;
    logic [1:0] pdst;
    logic       nsub;
    logic       dstart;
    logic [1:0] djob;
    logic       gcd_init;
    logic       zero_res;
  } rau_cmd_t;

  typedef struct packed {
    logic x_zero;
    logic d_done;
    logic g_zero;
  } rau_sts_t;
endpackage
`default_nettype wire

/* rtl/rau_if.sv */
// ---------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels of the rational arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none
interface rau_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             command;
  logic signed [rau_pkg::W-1:0] a_num;
  logic signed [rau_pkg::W-1:0] a_den;
  logic signed [rau_pkg::W-1:0] b_num;
  logic signed [rau_pkg::W-1:0] b_den;
  modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                   valid;
  logic                   ready;
  logic signed [rau_pkg::W-1:0] res_num;
  logic signed [rau_pkg::W-1:0] res_den;
  logic                   overflow;
  logic                   zero_divisor;
  modport source (output valid, res_num, res_den, overflow, zero_divisor, input ready);
  modport sink (input valid, res_num, res_den, overflow, zero_divisor, output ready);
endinterface
`default_nettype wire

/* rtl/rau_div.sv */
// ---------------------------------------------------------------------------
// rau_div
// Iterative signed truncating divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module rau_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [rau_pkg::W-1:0]  dividend,
  input  wire logic [rau_pkg::W-1:0]  divisor,
  output logic                        done,
  output logic [rau_pkg::W-1:0]       quo,
  output logic [rau_pkg::W-1:0]       rem
);
  localparam int W = rau_pkg::W;

  logic [W-1:0] q;
  logic [W-1:0] r;
  logic [W-1:0] dv;
  logic         qneg;
  logic         rneg;
  logic         busy;
  logic [rau_pkg::CW-1:0] cnt;
  logic [W:0]   trial;
  logic [W-1:0] r_shift;

  assign r_shift = {r[W-2:0], q[W-1]};
  assign trial = {1'b0, r_shift} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= rau_pkg::CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rau_pkg::CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= dividend[W-1] ? -dividend : dividend;
      dv   <= divisor[W-1] ? -divisor : divisor;
      r    <= '0;
      qneg <= dividend[W-1] ^ divisor[W-1];
      rneg <= dividend[W-1];
    end else if (busy) begin
      if (!trial[W]) begin
        r <= trial[W-1:0];
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= r_shift;
        q <= {q[W-2:0], 1'b0};
      end
    end
  end

  assign quo = qneg ? -q : q;
  assign rem = rneg ? -r : r;
endmodule
`default_nettype wire

/* rtl/rau_datapath.sv */
// ---------------------------------------------------------------------------
// rau_datapath
// Operand registers, multiplier, adder and Euclid registers.
// ---------------------------------------------------------------------------
`default_nettype none
module rau_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  rau_in_if.sink                 in_ch,
  input  wire rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_sts_t      sts,
  output logic [rau_pkg::W-1:0]  num,
  output logic [rau_pkg::W-1:0]  den,
  output logic                   ov
);
  localparam int W = rau_pkg::W;

  logic [W-1:0] an, ad, bn, bd;
  logic [W-1:0] tmp;
  logic [W-1:0] gx, gy;
  logic [W-1:0] ma, mb;
  logic [W-1:0] xa, xb;
  logic [2*W-1:0] mprod;
  logic         mneg;
  logic [W-1:0] pw;
  logic         mov;
  logic [W-1:0] sres;
  logic         sov;
  logic [W-1:0] dnd, dsr, dq, dr;
  logic         ddone;

  always_comb begin
    case (cmd.msel)
      rau_pkg::M_AN_BD: begin ma = an; mb = bd; end
      rau_pkg::M_AD_BN: begin ma = ad; mb = bn; end
      rau_pkg::M_AD_BD: begin ma = ad; mb = bd; end
      default:          begin ma = an; mb = bn; end
    endcase
  end

  assign xa    = ma[W-1] ? -ma : ma;
  assign xb    = mb[W-1] ? -mb : mb;
  assign mneg  = ma[W-1] ^ mb[W-1];
  assign mprod = {{W{1'b0}}, xa} * {{W{1'b0}}, xb};
  assign pw    = mneg ? -mprod[W-1:0] : mprod[W-1:0];
  assign mov   = (mprod[2*W-1:W] != '0) ||
                 (mprod[W-1:0] > ({1'b1, {(W-1){1'b0}}} - {{(W-1){1'b0}}, !mneg}));

  assign sres = cmd.nsub ? (tmp - pw) : (tmp + pw);
  assign sov  = cmd.nsub ? ((tmp[W-1] != pw[W-1]) && (sres[W-1] != tmp[W-1]))
                         : ((tmp[W-1] == pw[W-1]) && (sres[W-1] != tmp[W-1]));

  always_comb begin
    case (cmd.djob)
      rau_pkg::D_REM:  begin dnd = gy;  dsr = gx; end
      rau_pkg::D_QNUM: begin dnd = num; dsr = gy; end
      default:         begin dnd = den; dsr = gy; end
    endcase
  end

  rau_div u_div (
    .clk(clk), .rst(rst), .start(cmd.dstart), .dividend(dnd), .divisor(dsr),
    .done(ddone), .quo(dq), .rem(dr)
  );

  assign in_ch.ready = cmd.load;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an <= in_ch.a_num;
      ad <= in_ch.a_den;
      bn <= in_ch.b_num;
      bd <= in_ch.b_den;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_ch.valid) begin
      ov <= 1'b0;
    end else begin
      if (cmd.mul && mov) ov <= 1'b1;
      if (cmd.mul && cmd.pdst == rau_pkg::P_SUM && sov) ov <= 1'b1;
      if (ddone && cmd.djob != rau_pkg::D_REM && gy == '1 &&
          dnd == {1'b1, {(W-1){1'b0}}}) ov <= 1'b1;
    end
    if (cmd.mul) begin
      case (cmd.pdst)
        rau_pkg::P_NUM: num <= pw;
        rau_pkg::P_DEN: den <= pw;
        rau_pkg::P_TMP: tmp <= pw;
        default:        num <= sres;
      endcase
    end
    if (cmd.gcd_init) begin
      gx <= num;
      gy <= den;
    end else if (ddone && cmd.djob == rau_pkg::D_REM) begin
      gy <= gx;
      gx <= (gx == '1) ? '0 : dr;
    end else if (ddone && cmd.djob == rau_pkg::D_QNUM) begin
      num <= dq;
    end else if (ddone) begin
      den <= dq;
    end
    if (cmd.zero_res) begin
      num <= '0;
      den <= '0;
    end
  end

  assign sts.x_zero = (gx == '0);
  assign sts.d_done = ddone;
  assign sts.g_zero = (gy == '0);
endmodule
`default_nettype wire

/* rtl/rau_ctrl.sv */
// ---------------------------------------------------------------------------
// rau_ctrl
// Sequencer: products, Euclid loop, reducing divisions, result hold.
// ---------------------------------------------------------------------------
`default_nettype none
module rau_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        command,
  input  wire logic              out_ready,
  input  wire rau_pkg::rau_sts_t sts,
  output rau_pkg::rau_cmd_t      cmd,
  output logic                   out_valid
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_GI   = 4'd4;
  localparam logic [3:0] S_GT   = 4'd5;
  localparam logic [3:0] S_GW   = 4'd6;
  localparam logic [3:0] S_QN   = 4'd7;
  localparam logic [3:0] S_QNW  = 4'd8;
  localparam logic [3:0] S_QD   = 4'd9;
  localparam logic [3:0] S_QDW  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= rau_pkg::CMD_ADD;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) op <= command;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.djob = rau_pkg::D_REM;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.load = 1'b1;
        if (in_valid) state_next = S_M0;
      end
      S_M0: begin
        cmd.mul = 1'b1;
        cmd.msel = (op == rau_pkg::CMD_DIV) ? rau_pkg::M_AD_BN : rau_pkg::M_AD_BD;
        cmd.pdst = rau_pkg::P_DEN;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.mul = 1'b1;
        cmd.msel = (op == rau_pkg::CMD_MUL) ? rau_pkg::M_AN_BN : rau_pkg::M_AN_BD;
        cmd.pdst = (op == rau_pkg::CMD_ADD || op == rau_pkg::CMD_SUB) ?
                   rau_pkg::P_TMP : rau_pkg::P_NUM;
        state_next = (op == rau_pkg::CMD_ADD || op == rau_pkg::CMD_SUB) ? S_M2 : S_GI;
      end
      S_M2: begin
        cmd.mul = 1'b1;
        cmd.msel = rau_pkg::M_AD_BN;
        cmd.pdst = rau_pkg::P_SUM;
        cmd.nsub = (op == rau_pkg::CMD_SUB);
        state_next = S_GI;
      end
      S_GI: begin
        cmd.gcd_init = 1'b1;
        state_next = S_GT;
      end
      S_GT: begin
        if (sts.x_zero) begin
          if (sts.g_zero) begin
            cmd.zero_res = 1'b1;
            state_next = S_OUT;
          end else begin
            state_next = S_QN;
          end
        end else begin
          cmd.dstart = 1'b1;
          state_next = S_GW;
        end
      end
      S_GW: begin
        if (sts.d_done) state_next = S_GT;
      end
      S_QN: begin
        cmd.djob = rau_pkg::D_QNUM;
        cmd.dstart = 1'b1;
        state_next = S_QNW;
      end
      S_QNW: begin
        cmd.djob = rau_pkg::D_QNUM;
        if (sts.d_done) state_next = S_QD;
      end
      S_QD: begin
        cmd.djob = rau_pkg::D_QDEN;
        cmd.dstart = 1'b1;
        state_next = S_QDW;
      end
      S_QDW: begin
        cmd.djob = rau_pkg::D_QDEN;
        if (sts.d_done) state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_div_only_busy: assert property (@(posedge clk) disable iff (rst)
    sts.d_done |-> (state == S_GW || state == S_QNW || state == S_QDW)) else $error("div done");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("out dropped");
  a_start_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.dstart |=> (state == S_GW || state == S_QNW || state == S_QDW)) else $error("start");
endmodule
`default_nettype wire

/* rtl/rational_arithmetic_unit_core.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Fraction add/sub/mul/div with Euclid GCD reduction.
// ---------------------------------------------------------------------------
// channel  dir  fields
// in_ch    in   command, a_num, a_den, b_num, b_den
// out_ch   out  res_num, res_den, overflow, zero_divisor
//
// One item at a time. Two or three products and a load of the Euclid
// registers, then each Euclid step runs on the shared bit-serial
// divider, followed by two reducing divisions. Result holds until
// taken; the next item is taken after the output transfer. rst is
// synchronous and returns the sequencer to idle.
// ---------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_core (
  input  wire logic clk,
  input  wire logic rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .command(in_ch.command),
    .out_ready(out_ch.ready), .sts(sts), .cmd(cmd), .out_valid(out_ch.valid)
  );

  rau_datapath u_dp (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cmd(cmd), .sts(sts),
    .num(out_ch.res_num), .den(out_ch.res_den), .ov(out_ch.overflow)
  );

  logic zd;
  always_ff @(posedge clk) begin
    if (rst) zd <= 1'b0;
    else if (cmd.load) zd <= 1'b0;
    else if (cmd.zero_res) zd <= 1'b1;
  end
  assign out_ch.zero_divisor = zd;
endmodule
`default_nettype wire

/* tb/rational_arithmetic_unit_core_test.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit_core_test
// Checks fraction add/sub/mul/div with truncating Euclid GCD reduction.
// Directed corner operands and then random fractions are sent through the
// input channel in bursts. Each output transfer is compared with a predicted
// result, while the output side stalls at random and once for a long time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rational_arithmetic_unit_core_test;
  localparam int W = rau_pkg::W;

  typedef struct packed {
    logic [1:0]    command;
    logic [W-1:0]  a_num;
    logic [W-1:0]  a_den;
    logic [W-1:0]  b_num;
    logic [W-1:0]  b_den;
  } frac_op_t;

  typedef struct packed {
    logic [W-1:0] res_num;
    logic [W-1:0] res_den;
    logic         overflow;
    logic         zero_divisor;
  } frac_res_t;

  localparam longint MIN_W = -(64'sd1 <<< (W - 1));
  localparam longint MAX_W = (64'sd1 <<< (W - 1)) - 1;
  localparam int LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  rau_in_if in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  frac_op_t  pending_ops[$];
  frac_res_t expected_fracs[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_phase = 0;
  bit stim_done = 0;

  function automatic longint wrap32(longint v);
    return longint'(signed'(v[W-1:0]));
  endfunction

  function automatic longint mul_chk(longint a, longint b, ref bit ov);
    longint p;
    p = a * b;
    if (p > MAX_W || p < MIN_W) ov = 1;
    return wrap32(p);
  endfunction

  function automatic longint add_chk(longint a, longint b, ref bit ov);
    longint s;
    s = a + b;
    if (s > MAX_W || s < MIN_W) ov = 1;
    return wrap32(s);
  endfunction

  function automatic longint trunc_div(longint a, longint b, ref bit ov);
    if (b == -1) begin
      if (a == MIN_W) ov = 1;
      return wrap32(-a);
    end
    return a / b;
  endfunction

  function automatic frac_res_t reduce_fraction(frac_op_t op);
    longint an, ad, bn, bd, num, den, x, y, t;
    bit ov;
    frac_res_t r;
    ov = 0;
    an = longint'(signed'(op.a_num));
    ad = longint'(signed'(op.a_den));
    bn = longint'(signed'(op.b_num));
    bd = longint'(signed'(op.b_den));
    case (op.command)
      rau_pkg::CMD_ADD: begin
        den = mul_chk(ad, bd, ov);
        num = add_chk(mul_chk(an, bd, ov), mul_chk(ad, bn, ov), ov);
      end
      rau_pkg::CMD_SUB: begin
        den = mul_chk(ad, bd, ov);
        num = add_chk(mul_chk(an, bd, ov), -mul_chk(ad, bn, ov), ov);
      end
      rau_pkg::CMD_MUL: begin
        den = mul_chk(ad, bd, ov);
        num = mul_chk(an, bn, ov);
      end
      default: begin
        num = mul_chk(an, bd, ov);
        den = mul_chk(ad, bn, ov);
      end
    endcase
    x = num;
    y = den;
    while (x != 0) begin
      t = (x == -1) ? 0 : y % x;
      y = x;
      x = t;
    end
    r.zero_divisor = (y == 0);
    if (y == 0) begin
      num = 0;
      den = 0;
    end else begin
      num = trunc_div(num, y, ov);
      den = trunc_div(den, y, ov);
    end
    r.res_num = num[W-1:0];
    r.res_den = den[W-1:0];
    r.overflow = ov;
    return r;
  endfunction

  function automatic logic [W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return W'(MIN_W);
      1: return W'(MAX_W);
      2: return '0;
      3: return '1;
      4, 5: return W'(longint'($urandom_range(0, 40)) - 20);
      6, 7: return W'(longint'($urandom_range(0, 60000)) - 30000);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(logic [1:0] c, longint an, longint ad, longint bn, longint bd);
    frac_op_t op;
    op.command = c;
    op.a_num = W'(an);
    op.a_den = W'(ad);
    op.b_num = W'(bn);
    op.b_den = W'(bd);
    pending_ops.push_back(op);
  endtask

  initial begin
    frac_op_t op;
    push_op(rau_pkg::CMD_ADD, 1, 2, 1, 3);
    push_op(rau_pkg::CMD_SUB, 1, 2, 1, 2);
    push_op(rau_pkg::CMD_MUL, 2, 3, 3, 4);
    push_op(rau_pkg::CMD_DIV, 2, 3, 4, 9);
    push_op(rau_pkg::CMD_ADD, 0, 0, 0, 0);
    push_op(rau_pkg::CMD_DIV, 0, 5, 0, 7);
    push_op(rau_pkg::CMD_MUL, 0, 5, 7, 0);
    push_op(rau_pkg::CMD_SUB, 3, -1, 1, 1);
    push_op(rau_pkg::CMD_MUL, MIN_W, 1, 1, -1);
    push_op(rau_pkg::CMD_MUL, MIN_W, 1, -1, 1);
    push_op(rau_pkg::CMD_DIV, MIN_W, 1, 1, -1);
    push_op(rau_pkg::CMD_ADD, MAX_W, 1, MAX_W, 1);
    push_op(rau_pkg::CMD_SUB, MIN_W, 1, 1, 1);
    push_op(rau_pkg::CMD_MUL, MAX_W, MAX_W, MAX_W, MAX_W);
    push_op(rau_pkg::CMD_MUL, MIN_W, MIN_W, MIN_W, MIN_W);
    push_op(rau_pkg::CMD_DIV, -6, 4, 3, -8);
    push_op(rau_pkg::CMD_ADD, -1, -1, -1, -1);
    push_op(rau_pkg::CMD_DIV, 1, -1, 1, 1);
    push_op(rau_pkg::CMD_MUL, 46368, 1, 1, 28657);
    push_op(rau_pkg::CMD_ADD, MIN_W, 1, 0, 1);
    for (int i = 0; i < 350; i++) begin
      op.command = 2'($urandom_range(0, 3));
      op.a_num = pick_word();
      op.a_den = pick_word();
      op.b_num = pick_word();
      op.b_den = pick_word();
      pending_ops.push_back(op);
    end
    stim_done = 1;
  end

  // driver
  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.a_num = '0;
    in_ch.a_den = '0;
    in_ch.b_num = '0;
    in_ch.b_den = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 7) rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_fracs.push_back(reduce_fraction({in_ch.command, in_ch.a_num,
                                                  in_ch.a_den, in_ch.b_num, in_ch.b_den}));
        sent <= sent + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          {in_ch.command, in_ch.a_num, in_ch.a_den, in_ch.b_num, in_ch.b_den} <=
            pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 6);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frac_res_t got, want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.res_num, out_ch.res_den, out_ch.overflow, out_ch.zero_divisor};
        if (expected_fracs.size() == 0) begin
          $display("%0t: unexpected transfer %h", $time, got);
          errors++;
        end else begin
          want = expected_fracs.pop_front();
          if (got.res_num !== want.res_num)
            $display("%0t: res_num expected %h actual %h", $time, want.res_num, got.res_num);
          if (got.res_den !== want.res_den)
            $display("%0t: res_den expected %h actual %h", $time, want.res_den, got.res_den);
          if (got.overflow !== want.overflow)
            $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
          if (got.zero_divisor !== want.zero_divisor)
            $display("%0t: zero_divisor expected %b actual %b", $time,
                     want.zero_divisor, got.zero_divisor);
          if (got !== want) errors++;
        end
      end
      if (sent == 40 && hold_left == 0 && stall_phase == 0) begin
        hold_left <= 6000;
        stall_phase <= 1;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_phase <= (stall_phase == 0) ? 0 : stall_phase + 1;
        out_ch.ready <= ((cycles / 500) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while ((pending_ops.size() > 0 || in_ch.valid || expected_fracs.size() > 0)
           && cycles < LIMIT)
      @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    repeat (2000) @(posedge clk);
    if (errors == 0 && expected_fracs.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

/* filelist.f */
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_div.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit_core.sv
tb/rational_arithmetic_unit_core_test.sv
